@@ hw/rtl/lzeg_pkg.sv @@
// ---------------------------------------------------------------------------
// lzeg_pkg
// Shared types and constants of the LZ / Elias-gamma decompressor.
// ---------------------------------------------------------------------------
package lzeg_pkg;

  localparam int WIN_DEPTH = 4096;
  localparam int WIN_AW    = $clog2(WIN_DEPTH);
  localparam int CNT_W     = 17;

  localparam logic [WIN_AW-1:0] OFF_BIAS = WIN_AW'(129);

  typedef enum logic [2:0] {
    ST_BYTE     = 3'd0,
    ST_NEED     = 3'd1,
    ST_DONE     = 3'd2,
    ST_ACCEPTED = 3'd3,
    ST_REFUSED  = 3'd4,
    ST_OVERFLOW = 3'd5
  } status_t;

  typedef struct packed {
    logic       feed;
    logic       take_byte;
    logic       take_bit;
    logic       gamma_init;
    logic       gamma_shift;
    logic       copy_load;
    logic       off_byte;
    logic       off_bit;
    logic [1:0] off_sel;
    logic       rd_issue;
    logic       emit_lit;
    logic       emit_copy;
    logic       answer;
    status_t    ans_code;
  } dp_cmd_t;

  typedef struct packed {
    logic held_valid;
    logic held_msb;
    logic bit_ok;
    logic bit_val;
    logic gamma_ff;
    logic gamma_b16;
    logic copy_last;
  } dp_stat_t;

endpackage

@@ hw/rtl/lzeg_dp.sv @@
// ---------------------------------------------------------------------------
// lzeg_dp
// Datapath: holding slot, bit reader, gamma and offset registers, history
// memory and the result register.
// ---------------------------------------------------------------------------
module lzeg_dp import lzeg_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  dp_cmd_t          cmd,
  output dp_stat_t         stat,
  input  logic [7:0]       in_byte,
  input  logic             cfg_we,
  input  logic [CNT_W-1:0] cfg_data,
  input  logic             out_pop,
  output logic             out_valid,
  output status_t          out_status,
  output logic [7:0]       out_byte,
  output logic [CNT_W-1:0] out_addr
);

  logic [7:0]        win_mem [WIN_DEPTH];
  logic [7:0]        rd_data;
  logic [WIN_AW-1:0] wptr;
  logic [7:0]        held_byte;
  logic              held_valid;
  logic [7:0]        bit_buffer;
  logic [7:0]        bit_pointer;
  logic [CNT_W-1:0]  gamma;
  logic [WIN_AW-1:0] offset;
  logic [CNT_W-1:0]  copy_rem;
  logic [CNT_W-1:0]  out_count;
  logic [CNT_W-1:0]  dest_base;

  logic [7:0]        ptr_shift;
  logic              reload;
  logic              bit_val;
  logic [7:0]        emit_val;
  logic              emit;
  logic [WIN_AW-1:0] off_set;
  logic [3:0]        off_pos;

  assign ptr_shift = bit_pointer >> 1;
  assign reload    = (ptr_shift == 8'd0);
  assign bit_val   = reload ? held_byte[7] : |(bit_buffer & ptr_shift);
  assign emit      = cmd.emit_lit | cmd.emit_copy;
  assign emit_val  = cmd.emit_lit ? held_byte : rd_data;
  assign off_pos   = 4'd10 - {2'b00, cmd.off_sel};
  assign off_set   = offset | (WIN_AW'(bit_val) << off_pos);

  assign stat.held_valid = held_valid;
  assign stat.held_msb   = held_byte[7];
  assign stat.bit_ok     = !reload || held_valid;
  assign stat.bit_val    = bit_val;
  assign stat.gamma_ff   = &gamma[7:0];
  assign stat.gamma_b16  = gamma[CNT_W-1];
  assign stat.copy_last  = (copy_rem == CNT_W'(1));

  always_ff @(posedge clk) begin
    if (emit) begin
      win_mem[wptr] <= emit_val;
    end
    if (cmd.rd_issue) begin
      rd_data <= win_mem[wptr - offset];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr        <= '0;
      held_byte   <= '0;
      held_valid  <= 1'b0;
      bit_buffer  <= '0;
      bit_pointer <= '0;
      gamma       <= CNT_W'(1);
      offset      <= '0;
      copy_rem    <= '0;
      out_count   <= '0;
      dest_base   <= '0;
      out_valid   <= 1'b0;
      out_status  <= ST_BYTE;
      out_byte    <= '0;
      out_addr    <= '0;
    end else begin
      if (cfg_we) begin
        dest_base <= cfg_data;
      end
      if (cmd.feed) begin
        held_byte  <= in_byte;
        held_valid <= 1'b1;
      end
      if (cmd.take_byte) begin
        held_valid <= 1'b0;
      end
      if (cmd.take_bit) begin
        if (reload) begin
          bit_buffer  <= held_byte;
          held_valid  <= 1'b0;
          bit_pointer <= 8'h80;
        end else begin
          bit_pointer <= ptr_shift;
        end
      end
      if (cmd.gamma_init) begin
        gamma <= CNT_W'(1);
      end
      if (cmd.gamma_shift) begin
        gamma <= {gamma[CNT_W-2:0], bit_val};
      end
      if (cmd.copy_load) begin
        copy_rem <= gamma + CNT_W'(1);
      end
      if (cmd.emit_copy) begin
        copy_rem <= copy_rem - CNT_W'(1);
      end
      if (cmd.off_byte) begin
        offset <= held_byte[7] ? WIN_AW'(held_byte[6:0])
                               : WIN_AW'(held_byte) + WIN_AW'(1);
      end
      if (cmd.off_bit) begin
        // The last extension bit also folds in the bias of 128 plus one.
        offset <= (cmd.off_sel == 2'd3) ? off_set + OFF_BIAS : off_set;
      end
      if (out_pop) begin
        out_valid <= 1'b0;
      end
      if (emit) begin
        wptr       <= wptr + WIN_AW'(1);
        out_count  <= out_count + CNT_W'(1);
        out_valid  <= 1'b1;
        out_status <= ST_BYTE;
        out_byte   <= emit_val;
        out_addr   <= dest_base + out_count;
      end else if (cmd.answer) begin
        out_valid  <= 1'b1;
        out_status <= cmd.ans_code;
        out_byte   <= '0;
        out_addr   <= '0;
      end
    end
  end

endmodule

@@ hw/rtl/lzeg_ctrl.sv @@
// ---------------------------------------------------------------------------
// lzeg_ctrl
// Controller: request sequencing and the stream decode phase.
// ---------------------------------------------------------------------------
module lzeg_ctrl import lzeg_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_accept,
  input  logic     req_type,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd,
  output logic     busy
);

  typedef enum logic [1:0] {
    C_IDLE,
    C_STEP,
    C_READ
  } ctrl_state_t;

  typedef enum logic [3:0] {
    PH_FIRST,
    PH_FLAG,
    PH_LIT,
    PH_GSTOP,
    PH_GDATA,
    PH_OFFB,
    PH_OFFX0,
    PH_OFFX1,
    PH_OFFX2,
    PH_OFFX3,
    PH_COPY,
    PH_DONE,
    PH_ERR
  } phase_t;

  ctrl_state_t state, state_next;
  phase_t      phase, phase_next;

  assign busy = (state != C_IDLE);

  always_comb begin
    cmd        = '0;
    cmd.ans_code = ST_BYTE;
    state_next = state;
    phase_next = phase;
    unique case (state)
      C_IDLE: begin
        if (in_accept) begin
          if (req_type) begin
            state_next = C_STEP;
          end else begin
            cmd.answer = 1'b1;
            if (stat.held_valid) begin
              cmd.ans_code = ST_REFUSED;
            end else begin
              cmd.feed     = 1'b1;
              cmd.ans_code = ST_ACCEPTED;
            end
          end
        end
      end
      C_STEP: begin
        unique case (phase) inside
          PH_FIRST, PH_LIT: begin
            state_next = C_IDLE;
            if (!stat.held_valid) begin
              cmd.answer   = 1'b1;
              cmd.ans_code = ST_NEED;
            end else begin
              cmd.take_byte = 1'b1;
              cmd.emit_lit  = 1'b1;
              phase_next    = PH_FLAG;
            end
          end
          PH_OFFB: begin
            if (!stat.held_valid) begin
              cmd.answer   = 1'b1;
              cmd.ans_code = ST_NEED;
              state_next   = C_IDLE;
            end else begin
              cmd.take_byte = 1'b1;
              cmd.off_byte  = 1'b1;
              phase_next    = stat.held_msb ? PH_OFFX0 : PH_COPY;
            end
          end
          PH_FLAG, PH_GSTOP, PH_GDATA, PH_OFFX0, PH_OFFX1, PH_OFFX2, PH_OFFX3: begin
            if (!stat.bit_ok) begin
              cmd.answer   = 1'b1;
              cmd.ans_code = ST_NEED;
              state_next   = C_IDLE;
            end else begin
              cmd.take_bit = 1'b1;
              if (phase == PH_FLAG) begin
                if (stat.bit_val) begin
                  cmd.gamma_init = 1'b1;
                  phase_next     = PH_GSTOP;
                end else begin
                  phase_next = PH_LIT;
                end
              end else if (phase == PH_GSTOP) begin
                if (!stat.bit_val) begin
                  phase_next = PH_GDATA;
                end else if (stat.gamma_ff) begin
                  phase_next = PH_DONE;
                end else begin
                  cmd.copy_load = 1'b1;
                  phase_next    = PH_OFFB;
                end
              end else if (phase == PH_GDATA) begin
                if (stat.gamma_b16) begin
                  cmd.answer   = 1'b1;
                  cmd.ans_code = ST_OVERFLOW;
                  phase_next   = PH_ERR;
                  state_next   = C_IDLE;
                end else begin
                  cmd.gamma_shift = 1'b1;
                  phase_next      = PH_GSTOP;
                end
              end else begin
                cmd.off_bit = 1'b1;
                cmd.off_sel = 2'(phase - PH_OFFX0);
                phase_next  = (phase == PH_OFFX3) ? PH_COPY : phase_t'(phase + 4'd1);
              end
            end
          end
          PH_COPY: begin
            cmd.rd_issue = 1'b1;
            state_next   = C_READ;
          end
          PH_DONE: begin
            cmd.answer   = 1'b1;
            cmd.ans_code = ST_DONE;
            state_next   = C_IDLE;
          end
          default: begin
            cmd.answer   = 1'b1;
            cmd.ans_code = ST_OVERFLOW;
            phase_next   = PH_ERR;
            state_next   = C_IDLE;
          end
        endcase
      end
      C_READ: begin
        cmd.emit_copy = 1'b1;
        if (stat.copy_last) begin
          phase_next = PH_FLAG;
        end
        state_next = C_IDLE;
      end
      default: begin
        state_next = C_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= C_IDLE;
      phase <= PH_FIRST;
    end else begin
      state <= state_next;
      phase <= phase_next;
    end
  end

endmodule

@@ hw/rtl/lz_elias_gamma_decompressor_top.sv @@
// ---------------------------------------------------------------------------
// lz_elias_gamma_decompressor_top
// Byte-at-a-time LZ decompressor with Elias-gamma lengths and a 4 KiB
// history window.
//
//   channel | direction | handshake         | payload
//   in      | to block  | in_valid/in_stall | req_type, in_byte
//   out     | from blk  | out_valid/out_stall | status, out_byte, out_addr
//   cfg     | to block  | cfg_valid/cfg_ready | cfg_data (dest_base)
//
// A feed's answer is registered in the cycle after it is taken. A pull walks
// one flag, gamma or offset step per cycle and ends in a literal, a copy byte
// (after the registered window read) or a status word.
// A new word is taken only after the previous answer has left the result
// register. The window needs no clearing.
// ---------------------------------------------------------------------------
module lz_elias_gamma_decompressor_top import lzeg_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic             req_type,
  input  logic [7:0]       in_byte,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [2:0]       status,
  output logic [7:0]       out_byte,
  output logic [16:0]      out_addr,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [16:0]      cfg_data
);

  dp_cmd_t  cmd;
  dp_stat_t stat;
  status_t  out_status;
  logic     busy;
  logic     in_accept;

  assign cfg_ready = 1'b1;
  assign in_stall  = busy | out_valid;
  assign in_accept = in_valid & !in_stall;
  assign status    = out_status;

  lzeg_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_accept (in_accept),
    .req_type  (req_type),
    .stat      (stat),
    .cmd       (cmd),
    .busy      (busy)
  );

  lzeg_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .in_byte    (in_byte),
    .cfg_we     (cfg_valid & cfg_ready),
    .cfg_data   (cfg_data),
    .out_pop    (out_valid & !out_stall),
    .out_valid  (out_valid),
    .out_status (out_status),
    .out_byte   (out_byte),
    .out_addr   (out_addr)
  );

  a_rd_then_emit: assert property (@(posedge clk) disable iff (rst)
    cmd.rd_issue |=> cmd.emit_copy)
    else $error("window read not followed by a copy byte");

  a_accept_progress: assert property (@(posedge clk) disable iff (rst)
    in_accept |=> (out_valid || busy))
    else $error("accepted word left no answer and no work");

  a_busy_empty: assert property (@(posedge clk) disable iff (rst)
    busy |-> !out_valid)
    else $error("decoder running while a result is pending");

endmodule

@@ test/lz_elias_gamma_decompressor_top_test.sv @@
// ---------------------------------------------------------------------------
// LZ / Elias-gamma decompressor testbench
// Encodes one long compressed stream on the fly and sends it to the block as
// a mix of feed and pull words. The stream holds literals, matches of many
// lengths and offsets, and an end marker. A behavioral model predicts every
// answer, and the checker compares status, byte and address in order. The
// destination base is changed between phases, both handshakes idle at
// random, and the receiver once holds off long enough to fill the block.
// ---------------------------------------------------------------------------
module lz_elias_gamma_decompressor_top_test;
  import lzeg_pkg::*;

  typedef enum int {
    P_FIRST, P_FLAG, P_LIT, P_GSTOP, P_GDATA, P_OFFB, P_OFFX, P_COPY, P_DONE, P_ERR
  } phase_t;

  typedef struct {
    status_t     st;
    logic [7:0]  b;
    logic [16:0] a;
  } answer_t;

  logic        clk = 0;
  logic        rst = 1;
  logic        in_valid = 0;
  logic        in_stall;
  logic        req_type = 0;
  logic [7:0]  in_byte = 0;
  logic        out_valid;
  logic        out_stall = 0;
  logic [2:0]  status;
  logic [7:0]  out_byte;
  logic [16:0] out_addr;
  logic        cfg_valid = 0;
  logic        cfg_ready;
  logic [16:0] cfg_data = 0;

  lz_elias_gamma_decompressor_top DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .req_type(req_type), .in_byte(in_byte),
    .out_valid(out_valid), .out_stall(out_stall),
    .status(status), .out_byte(out_byte), .out_addr(out_addr),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  // Decoder state as the block should hold it.
  logic [7:0]  win_mem [WIN_DEPTH];
  logic [11:0] win_ptr;
  logic [7:0]  held_b;
  logic        held_v;
  logic [7:0]  bit_buf;
  logic [7:0]  bit_ptr;
  phase_t      phase;
  int          xsel;
  logic [16:0] gamma_acc;
  logic [11:0] match_off;
  logic [16:0] copy_left;
  logic [16:0] out_count;
  logic [16:0] dest_base;

  // Compressed stream under construction.
  logic [7:0]  stream_q [$];
  int          feed_pos;
  int          bit_idx;
  logic [7:0]  flag_pos;
  int          enc_outputs;

  answer_t     answers_q [$];
  int          mismatches, unexpected, bytes_seen, need_seen, refused_seen, done_seen;
  int          words_sent, burst_left;
  bit          hold_rx;

  function automatic bit take_bit(output logic v);
    logic [7:0] nxt;
    nxt = bit_ptr >> 1;
    if (nxt == 0) begin
      if (!held_v) return 0;
      bit_buf = held_b;
      held_v = 0;
      nxt = 8'h80;
    end
    bit_ptr = nxt;
    v = |(bit_buf & bit_ptr);
    return 1;
  endfunction

  function automatic void emit_byte(input logic [7:0] v, output answer_t r);
    win_mem[win_ptr] = v;
    win_ptr++;
    r.st = ST_BYTE;
    r.b = v;
    r.a = dest_base + out_count;
    out_count++;
  endfunction

  function automatic answer_t predict_word(input logic req, input logic [7:0] b);
    answer_t r;
    logic    v;
    r.st = ST_BYTE;
    r.b = 0;
    r.a = 0;
    if (!req) begin
      if (held_v) r.st = ST_REFUSED;
      else begin
        held_b = b;
        held_v = 1;
        r.st = ST_ACCEPTED;
      end
      return r;
    end
    forever begin
      case (phase)
        P_FIRST, P_LIT: begin
          if (!held_v) begin
            r.st = ST_NEED;
            return r;
          end
          held_v = 0;
          phase = P_FLAG;
          emit_byte(held_b, r);
          return r;
        end
        P_FLAG: begin
          if (!take_bit(v)) begin
            r.st = ST_NEED;
            return r;
          end
          if (v) begin
            gamma_acc = 1;
            phase = P_GSTOP;
          end else phase = P_LIT;
        end
        P_GSTOP: begin
          if (!take_bit(v)) begin
            r.st = ST_NEED;
            return r;
          end
          if (!v) phase = P_GDATA;
          else if (gamma_acc[7:0] == 8'hFF) phase = P_DONE;
          else begin
            copy_left = gamma_acc + 1;
            phase = P_OFFB;
          end
        end
        P_GDATA: begin
          if (!take_bit(v)) begin
            r.st = ST_NEED;
            return r;
          end
          if (gamma_acc[16]) begin
            phase = P_ERR;
            r.st = ST_OVERFLOW;
            return r;
          end
          gamma_acc = {gamma_acc[15:0], v};
          phase = P_GSTOP;
        end
        P_OFFB: begin
          if (!held_v) begin
            r.st = ST_NEED;
            return r;
          end
          held_v = 0;
          if (!held_b[7]) begin
            match_off = held_b + 1;
            phase = P_COPY;
          end else begin
            match_off = held_b[6:0];
            xsel = 0;
            phase = P_OFFX;
          end
        end
        P_OFFX: begin
          if (!take_bit(v)) begin
            r.st = ST_NEED;
            return r;
          end
          match_off[10 - xsel] = v;
          if (xsel == 3) begin
            match_off = match_off + 129;
            phase = P_COPY;
          end else xsel++;
        end
        P_COPY: begin
          copy_left--;
          if (copy_left == 0) phase = P_FLAG;
          emit_byte(win_mem[win_ptr - match_off], r);
          return r;
        end
        P_DONE: begin
          r.st = ST_DONE;
          return r;
        end
        default: begin
          phase = P_ERR;
          r.st = ST_OVERFLOW;
          return r;
        end
      endcase
    end
  endfunction

  // ---- stream encoder ----
  function automatic void put_bit(input logic v);
    if (flag_pos == 0) begin
      stream_q.push_back(8'h00);
      bit_idx = stream_q.size() - 1;
      flag_pos = 8'h80;
    end
    if (v) stream_q[bit_idx] |= flag_pos;
    flag_pos >>= 1;
  endfunction

  function automatic void put_gamma(input logic [16:0] g);
    int top;
    top = 0;
    for (int i = 0; i < 17; i++) if (g[i]) top = i;
    for (int i = top - 1; i >= 0; i--) begin
      put_bit(0);
      put_bit(g[i]);
    end
    put_bit(1);
  endfunction

  function automatic void enc_literal(input logic [7:0] v);
    if (enc_outputs > 0) put_bit(0);
    stream_q.push_back(v);
    enc_outputs++;
  endfunction

  // span is the copy distance, 1 .. 2176; it never exceeds the bytes produced.
  function automatic void enc_match(input int len, input int span);
    logic [10:0] o;
    put_bit(1);
    put_gamma(len - 1);
    if (span <= 128) stream_q.push_back(span - 1);
    else begin
      o = span - 129;
      stream_q.push_back({1'b1, o[6:0]});
      for (int i = 10; i >= 7; i--) put_bit(o[i]);
    end
    enc_outputs += len;
  endfunction

  function automatic void enc_end();
    put_bit(1);
    put_gamma(255);
    flag_pos = 0;
  endfunction

  function automatic void enc_random_token();
    int len, span, maxspan, r;
    if (enc_outputs < 2 || $urandom_range(0, 99) < 40) begin
      enc_literal($urandom);
      return;
    end
    r = $urandom_range(0, 99);
    if (r < 80) len = $urandom_range(2, 12);
    else if (r < 97) len = $urandom_range(13, 200);
    else len = $urandom_range(201, 700);
    if (((len - 1) & 255) == 255) len++;
    maxspan = (enc_outputs < 2176) ? enc_outputs : 2176;
    r = $urandom_range(0, 9);
    if (r == 0) span = maxspan;
    else if (r == 1 && maxspan >= 129) span = $urandom_range(0, 1) ? 128 : 129;
    else if (r < 6) span = $urandom_range(1, (maxspan < 16) ? maxspan : 16);
    else span = $urandom_range(1, maxspan);
    enc_match(len, span);
  endfunction

  function automatic bit feedable();
    return feed_pos < stream_q.size() && (flag_pos == 0 || feed_pos < bit_idx);
  endfunction

  // ---- handshakes ----
  task automatic send_word(input logic req, input logic [7:0] b);
    answers_q.push_back(predict_word(req, b));
    words_sent++;
    in_valid <= 1;
    req_type <= req;
    in_byte <= b;
    do @(posedge clk); while (in_stall);
    if (burst_left > 0) burst_left--;
    else begin
      in_valid <= 0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = $urandom_range(0, 40);
    end
  endtask

  task automatic write_dest(input logic [16:0] v);
    cfg_valid <= 1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 0;
    dest_base = v;
  endtask

  task automatic wait_idle();
    in_valid <= 0;
    while (answers_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Sends n words of the stream, adding tokens when the stream runs dry.
  // With grow cleared it stops early once the decoder has seen the end marker.
  task automatic play(input int n, input bit grow);
    int sent, r;
    sent = 0;
    while (sent < n && !(phase == P_DONE && !grow)) begin
      r = $urandom_range(0, 99);
      if (held_v) begin
        if (r < 6) send_word(0, $urandom);
        else send_word(1, $urandom);
        sent++;
      end else if (feedable()) begin
        if (r < 80) begin
          send_word(0, stream_q[feed_pos]);
          feed_pos++;
        end else send_word(1, $urandom);
        sent++;
      end else if (grow) enc_random_token();
      else begin
        send_word(1, $urandom);
        sent++;
      end
    end
  endtask

  task automatic test_directed();
    write_dest(17'h1FFFF);
    enc_literal(8'h00);
    enc_literal(8'hFF);
    enc_match(2, 1);
    enc_match(255, 2);
    enc_literal(8'hA5);
    play(25, 1);
    wait_idle();
  endtask

  task automatic test_random();
    logic [16:0] bases [4];
    bases = '{17'h00000, 17'h1FFFE, 17'h00000, 17'h1FFFF};
    foreach (bases[i]) begin
      write_dest(i == 2 ? 17'($urandom) : bases[i]);
      play(380, 1);
      wait_idle();
    end
  endtask

  task automatic test_backpressure();
    fork
      begin
        hold_rx = 1;
        repeat (300) @(posedge clk);
        hold_rx = 0;
      end
      play(60, 1);
    join
    wait_idle();
  endtask

  task automatic test_end_of_stream();
    enc_end();
    play(100000, 0);
    for (int i = 0; i < 3; i++) send_word(1, $urandom);
    send_word(0, $urandom);
    send_word(0, $urandom);
    send_word(1, $urandom);
  endtask

  // Receiver: stall pattern switches among none, random and alternate.
  always @(posedge clk) begin
    static int mode = 0, left = 0, tick = 0;
    if (left == 0) begin
      mode = $urandom_range(0, 2);
      left = $urandom_range(20, 200);
    end
    left--;
    tick++;
    out_stall <= hold_rx || (mode == 1 && $urandom_range(0, 99) < 35) ||
                 (mode == 2 && tick[0]);
  end

  always @(posedge clk) begin
    answer_t e;
    if (!rst && out_valid && !out_stall) begin
      if (answers_q.size() == 0) begin
        unexpected++;
        if (mismatches + unexpected <= 10)
          $display("unexpected word: status %0d byte %h addr %h", status, out_byte, out_addr);
      end else begin
        e = answers_q.pop_front();
        if (status !== e.st || out_byte !== e.b || out_addr !== e.a) begin
          mismatches++;
          if (mismatches + unexpected <= 10)
            $display("mismatch: expected status %0d byte %h addr %h, got %0d %h %h",
                     e.st, e.b, e.a, status, out_byte, out_addr);
        end
        case (e.st)
          ST_BYTE:    bytes_seen++;
          ST_NEED:    need_seen++;
          ST_REFUSED: refused_seen++;
          ST_DONE:    done_seen++;
          default: ;
        endcase
      end
    end
  end

  initial begin
    foreach (win_mem[i]) win_mem[i] = 0;
    win_ptr = 0; held_b = 0; held_v = 0; bit_buf = 0; bit_ptr = 0;
    phase = P_FIRST; xsel = 0; gamma_acc = 1; match_off = 0; copy_left = 0;
    out_count = 0; dest_base = 0;
    feed_pos = 0; bit_idx = -1; flag_pos = 0; enc_outputs = 0;
    mismatches = 0; unexpected = 0; bytes_seen = 0; need_seen = 0;
    refused_seen = 0; done_seen = 0; words_sent = 0; burst_left = 0; hold_rx = 0;
    repeat (4) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    test_directed();
    test_random();
    test_backpressure();
    test_end_of_stream();
    wait_idle();
    $display("sent %0d words over a %0d-byte stream with the end marker", words_sent,
             stream_q.size());
    $display("answers: %0d bytes, %0d need-input, %0d refused, %0d finished",
             bytes_seen, need_seen, refused_seen, done_seen);
    if (mismatches == 0 && unexpected == 0 && answers_q.size() == 0)
      $display("[lz_elias_gamma_decompressor_top] OK");
    else
      $display("[lz_elias_gamma_decompressor_top] ERROR");
    $finish;
  end

  initial begin
    #5000000;
    $display("[lz_elias_gamma_decompressor_top] ERROR");
    $finish;
  end

endmodule
